/* sv/general_purpose_reload_timer_unit_macros.svh */
// Assertion macros for the general-purpose reload timer unit.
// Included by modules that carry concurrent checks; empty under synthesis.
`ifndef GENERAL_PURPOSE_RELOAD_TIMER_UNIT_MACROS_SVH
`define GENERAL_PURPOSE_RELOAD_TIMER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// check with reset disable
`define GPRT_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check that also holds during reset
`define GPRT_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GPRT_ASSERT(label, clk, rst_n, prop, msg)
`define GPRT_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

/* sv/gprt_pkg.sv */
// Package for the general-purpose reload timer unit: widths, codes, item types.
// No dependencies.
`timescale 1ns / 1ps

package gprt_pkg;

  localparam int COUNT_WIDTH = 16;
  localparam int IN_DATA_W   = 24;
  localparam int OUT_DATA_W  = 24;

  typedef logic [COUNT_WIDTH-1:0] cnt_t;

  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  localparam logic [3:0] REG_CTRL    = 4'd0;
  localparam logic [3:0] REG_INTEN   = 4'd1;
  localparam logic [3:0] REG_STATUS  = 4'd2;
  localparam logic [3:0] REG_GEN     = 4'd3;
  localparam logic [3:0] REG_COUNT   = 4'd4;
  localparam logic [3:0] REG_PRESC   = 4'd5;
  localparam logic [3:0] REG_RELOAD  = 4'd6;
  localparam logic [3:0] REG_REMAIN  = 4'd7;
  localparam logic [3:0] REG_ELAPSED = 4'd8;

  // control bit positions
  localparam int CTL_EN   = 0;
  localparam int CTL_OPM  = 1;
  localparam int CTL_DIR  = 2;
  localparam int CTL_URS  = 3;
  localparam int CTL_UDIS = 4;

  typedef struct packed {
    logic [15:0] wdata;
    logic [3:0]  reg_addr;
    logic [1:0]  cmd;
  } item_t;

  typedef struct packed {
    logic        update_event;
    logic        irq;
    logic [15:0] read_data;
  } result_t;

endpackage

/* sv/general_purpose_reload_timer_unit.sv */
// Top level of the general-purpose reload timer unit: stream handshake,
// input register and result register around gprt_core. Depends on gprt_pkg.
`timescale 1ns / 1ps

// One item (a timer tick, a register write or a register read) is accepted
// every clock cycle when the result side keeps up; each item yields exactly one
// result: it waits in the input register, where the counter, prescaler and
// register file are updated by a single pass of logic, then passes to the
// result register. Timer time advances only with tick items, never with the
// bus clock on its own.
module general_purpose_reload_timer_unit
  import gprt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // cmd[1:0], reg_addr[5:2], wdata[21:6]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata   // read_data[15:0], irq[16], update_event[17]
);

  logic    stg_v_r;
  item_t   stg_r;
  logic    out_v_r;
  result_t out_r;
  logic    adv;
  result_t res;

  assign adv       = stg_v_r && (!out_v_r || out_tready);
  assign in_tready = !stg_v_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_tready) begin
        stg_v_r <= in_tvalid;
      end
      if (adv) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      stg_r <= item_t'(in_tdata[$bits(item_t)-1:0]);
    end
    if (adv) begin
      out_r <= res;
    end
  end

  gprt_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (adv),
    .item  (stg_r),
    .res   (res)
  );

  assign out_tvalid = out_v_r;
  assign out_tdata  = {{(OUT_DATA_W - $bits(result_t)){1'b0}}, out_r};

endmodule

/* sv/gprt_core.sv */
// Timer state and single-pass item processing for the reload timer unit.
// Depends on gprt_pkg and general_purpose_reload_timer_unit_macros.svh.
`timescale 1ns / 1ps
`include "general_purpose_reload_timer_unit_macros.svh"

module gprt_core
  import gprt_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    fire,
  input  item_t   item,
  output result_t res
);

  logic [4:0]  ctrl_r, ctrl_nxt;
  logic [1:0]  inten_r, inten_nxt;
  logic        flag_r, flag_nxt;
  cnt_t        cnt_r, cnt_nxt;
  logic [15:0] psc_pre_r, psc_pre_nxt;
  logic [15:0] psc_act_r, psc_act_nxt;
  logic [15:0] psc_cnt_r, psc_cnt_nxt;
  cnt_t        reload_r, reload_nxt;

  logic        wrapped;
  logic        ev;
  logic [15:0] rd;
  cnt_t        diff;

  assign diff = reload_r - cnt_r;

  always_comb begin
    ctrl_nxt    = ctrl_r;
    inten_nxt   = inten_r;
    flag_nxt    = flag_r;
    cnt_nxt     = cnt_r;
    psc_pre_nxt = psc_pre_r;
    psc_act_nxt = psc_act_r;
    psc_cnt_nxt = psc_cnt_r;
    reload_nxt  = reload_r;
    wrapped     = 1'b0;
    ev          = 1'b0;
    rd          = '0;
    unique case (item.cmd)
      CMD_TICK: begin
        if (ctrl_r[CTL_EN]) begin
          if (psc_cnt_r < psc_act_r) begin
            psc_cnt_nxt = psc_cnt_r + 16'd1;
          end else begin
            psc_cnt_nxt = '0;
            if (ctrl_r[CTL_DIR]) begin
              wrapped = (cnt_r == '0);
              cnt_nxt = wrapped ? reload_r : cnt_r - cnt_t'(1);
            end else begin
              wrapped = (cnt_r >= reload_r);
              cnt_nxt = wrapped ? '0 : cnt_r + cnt_t'(1);
            end
            if (wrapped && !ctrl_r[CTL_UDIS]) begin
              ev          = 1'b1;
              flag_nxt    = 1'b1;
              psc_act_nxt = psc_pre_r;
              if (ctrl_r[CTL_OPM]) begin
                ctrl_nxt[CTL_EN] = 1'b0;
              end
            end
          end
        end
      end
      CMD_WRITE: begin
        unique case (item.reg_addr)
          REG_CTRL:   ctrl_nxt    = item.wdata[4:0];
          REG_INTEN:  inten_nxt   = item.wdata[1:0];
          REG_STATUS: flag_nxt    = flag_r & item.wdata[0];
          REG_GEN: begin
            if (item.wdata[0]) begin
              cnt_nxt     = ctrl_r[CTL_DIR] ? reload_r : '0;
              psc_cnt_nxt = '0;
              if (!ctrl_r[CTL_UDIS]) begin
                psc_act_nxt = psc_pre_r;
                if (!ctrl_r[CTL_URS]) begin
                  flag_nxt = 1'b1;
                end
              end
            end
          end
          REG_COUNT:  cnt_nxt     = cnt_t'(item.wdata);
          REG_PRESC:  psc_pre_nxt = item.wdata;
          REG_RELOAD: reload_nxt  = cnt_t'(item.wdata);
          default: ;
        endcase
      end
      CMD_READ: begin
        unique case (item.reg_addr)
          REG_CTRL:    rd = {11'd0, ctrl_r};
          REG_INTEN:   rd = {14'd0, inten_r};
          REG_STATUS:  rd = {15'd0, flag_r};
          REG_COUNT:   rd = cnt_r[15:0];
          REG_PRESC:   rd = psc_pre_r;
          REG_RELOAD:  rd = reload_r[15:0];
          REG_REMAIN:  rd = ctrl_r[CTL_DIR] ? cnt_r[15:0] : diff[15:0];
          REG_ELAPSED: rd = ctrl_r[CTL_DIR] ? diff[15:0] : cnt_r[15:0];
          default:     rd = '0;
        endcase
      end
      default: ;
    endcase
  end

  assign res.read_data    = rd;
  assign res.irq          = flag_nxt & inten_nxt[0];
  assign res.update_event = ev;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r    <= '0;
      inten_r   <= '0;
      flag_r    <= 1'b0;
      cnt_r     <= '0;
      psc_pre_r <= '0;
      psc_act_r <= '0;
      psc_cnt_r <= '0;
      reload_r  <= '1;
    end else if (fire) begin
      ctrl_r    <= ctrl_nxt;
      inten_r   <= inten_nxt;
      flag_r    <= flag_nxt;
      cnt_r     <= cnt_nxt;
      psc_pre_r <= psc_pre_nxt;
      psc_act_r <= psc_act_nxt;
      psc_cnt_r <= psc_cnt_nxt;
      reload_r  <= reload_nxt;
    end
  end

  `GPRT_ASSERT(a_ev_only_on_tick, clk, rst_n, (fire && res.update_event) |-> (item.cmd == CMD_TICK), "update event outside a tick")
  `GPRT_ASSERT(a_ev_sets_flag, clk, rst_n, (fire && res.update_event) |=> flag_r, "update did not set flag")
  `GPRT_ASSERT(a_opm_stops, clk, rst_n, (fire && res.update_event && ctrl_r[CTL_OPM]) |=> !ctrl_r[CTL_EN], "one-shot did not stop timer")
  `GPRT_ASSERT(a_idle_holds, clk, rst_n, (!fire && $past(rst_n)) |=> $stable(cnt_r) && $stable(flag_r), "state moved without a transfer")

endmodule

/* tb/tb_general_purpose_reload_timer_unit.sv */
// Testbench for general_purpose_reload_timer_unit: directed and random ticks and register
// accesses, with every result checked against a cycle-free model of the timer.
// Depends on gprt_pkg and the unit itself.
`timescale 1ns / 1ps

module tb_general_purpose_reload_timer_unit;
  import gprt_pkg::*;

  localparam logic [1:0] CMD_SPARE   = 2'd3;
  localparam logic [3:0] REG_UNKNOWN = 4'd15;
  localparam int         CYCLE_LIMIT = 400000;
  localparam int         PIPE_DEPTH  = 2;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  general_purpose_reload_timer_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #2 clk = ~clk;

  // timer model state
  logic [4:0] ctl_bits = '0;
  logic [1:0] irq_enables = '0;
  logic       upd_flag = 1'b0;
  cnt_t       counter = '0;
  logic [15:0] psc_preload = '0;
  logic [15:0] psc_active = '0;
  logic [15:0] psc_count = '0;
  cnt_t       auto_reload = '1;

  result_t pending_results[$];
  int      mismatch_count = 0;
  int      cycle_count = 0;
  int      send_idle_pct = 0;
  int      recv_stall_pct = 0;
  int      hold_off_cycles = 0;

  function automatic result_t predict_timer_result(input item_t it);
    result_t res;
    logic    wrapped;
    res = '0;
    wrapped = 1'b0;
    case (it.cmd)
      CMD_TICK: begin
        if (ctl_bits[CTL_EN]) begin
          if (psc_count < psc_active) begin
            psc_count = psc_count + 16'd1;
          end else begin
            psc_count = '0;
            if (ctl_bits[CTL_DIR]) begin
              wrapped = (counter == '0);
              counter = wrapped ? auto_reload : counter - cnt_t'(1);
            end else begin
              wrapped = (counter >= auto_reload);
              counter = wrapped ? '0 : counter + cnt_t'(1);
            end
            if (wrapped && !ctl_bits[CTL_UDIS]) begin
              upd_flag = 1'b1;
              psc_active = psc_preload;
              if (ctl_bits[CTL_OPM]) ctl_bits[CTL_EN] = 1'b0;
              res.update_event = 1'b1;
            end
          end
        end
      end
      CMD_WRITE: begin
        case (it.reg_addr)
          REG_CTRL:   ctl_bits = it.wdata[4:0];
          REG_INTEN:  irq_enables = it.wdata[1:0];
          REG_STATUS: upd_flag = upd_flag & it.wdata[0];
          REG_GEN: begin
            if (it.wdata[0]) begin
              counter = ctl_bits[CTL_DIR] ? auto_reload : '0;
              psc_count = '0;
              if (!ctl_bits[CTL_UDIS]) begin
                psc_active = psc_preload;
                if (!ctl_bits[CTL_URS]) upd_flag = 1'b1;
              end
            end
          end
          REG_COUNT:  counter = it.wdata;
          REG_PRESC:  psc_preload = it.wdata;
          REG_RELOAD: auto_reload = it.wdata;
          default: ;
        endcase
      end
      CMD_READ: begin
        case (it.reg_addr)
          REG_CTRL:    res.read_data = 16'(ctl_bits);
          REG_INTEN:   res.read_data = 16'(irq_enables);
          REG_STATUS:  res.read_data = 16'(upd_flag);
          REG_COUNT:   res.read_data = counter;
          REG_PRESC:   res.read_data = psc_preload;
          REG_RELOAD:  res.read_data = auto_reload;
          REG_REMAIN:  res.read_data = ctl_bits[CTL_DIR] ? counter : auto_reload - counter;
          REG_ELAPSED: res.read_data = ctl_bits[CTL_DIR] ? auto_reload - counter : counter;
          default:     res.read_data = '0;
        endcase
      end
      default: ;
    endcase
    res.irq = upd_flag & irq_enables[0];
    return res;
  endfunction

  task automatic send_item(input logic [1:0] cmd, input logic [3:0] addr,
                           input logic [15:0] data);
    item_t it;
    it.cmd = cmd;
    it.reg_addr = addr;
    it.wdata = data;
    in_tdata  <= IN_DATA_W'(it);
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_results.push_back(predict_timer_result(it));
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic wait_for_drain();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // mostly well-formed traffic: small reloads and prescalers so that wraps happen often
  task automatic send_random_item();
    int          sel;
    logic [1:0]  cmd;
    logic [3:0]  addr;
    logic [15:0] data;
    sel  = $urandom_range(99);
    addr = 4'($urandom_range(8));
    data = 16'($urandom);
    cmd  = CMD_TICK;
    if (sel >= 55 && sel < 80) begin
      cmd = CMD_WRITE;
      case (addr)
        REG_CTRL: begin
          if ($urandom_range(3) != 0) begin
            data[CTL_EN]   = 1'b1;
            data[CTL_UDIS] = ($urandom_range(4) == 0);
          end
        end
        REG_PRESC:  if ($urandom_range(15) != 0) data = 16'($urandom_range(3));
        REG_RELOAD: if ($urandom_range(7) != 0) data = 16'($urandom_range(12));
        REG_COUNT:  if ($urandom_range(3) != 0) data = 16'($urandom_range(16));
        default: ;
      endcase
    end else if (sel >= 80 && sel < 95) begin
      cmd = CMD_READ;
    end else if (sel >= 95 && sel < 97) begin
      cmd = CMD_SPARE;
    end else if (sel >= 97) begin
      cmd  = $urandom_range(1) ? CMD_WRITE : CMD_READ;
      addr = 4'($urandom_range(9, 15));
    end
    send_item(cmd, addr, data);
  endtask

  task automatic test_reset_values();
    send_item(CMD_READ, REG_CTRL, '0);
    send_item(CMD_READ, REG_RELOAD, '0);
    send_item(CMD_READ, REG_ELAPSED, '0);
    send_item(CMD_READ, REG_GEN, '0);
    send_item(CMD_READ, REG_UNKNOWN, '1);
    send_item(CMD_SPARE, REG_UNKNOWN, '1);
  endtask

  task automatic test_one_shot_overflow();
    send_item(CMD_WRITE, REG_RELOAD, 16'd1);
    send_item(CMD_WRITE, REG_INTEN, 16'd3);
    send_item(CMD_WRITE, REG_CTRL, 16'((1 << CTL_EN) | (1 << CTL_OPM)));
    repeat (3) send_item(CMD_TICK, '0, '0);
    send_item(CMD_WRITE, REG_STATUS, 16'd1);
    send_item(CMD_WRITE, REG_STATUS, 16'd0);
    send_item(CMD_WRITE, REG_ELAPSED, 16'hFFFF);
  endtask

  task automatic test_update_disable();
    send_item(CMD_WRITE, REG_COUNT, 16'hFFFF);
    send_item(CMD_WRITE, REG_CTRL, 16'((1 << CTL_EN) | (1 << CTL_UDIS)));
    send_item(CMD_TICK, '0, '0);
  endtask

  task automatic test_generate_down();
    send_item(CMD_WRITE, REG_CTRL, 16'((1 << CTL_EN) | (1 << CTL_DIR) | (1 << CTL_URS)));
    send_item(CMD_WRITE, REG_PRESC, 16'd1);
    send_item(CMD_WRITE, REG_GEN, 16'hFFFF);
    repeat (2) send_item(CMD_TICK, '0, '0);
    send_item(CMD_READ, REG_REMAIN, '0);
    send_item(CMD_READ, REG_ELAPSED, '0);
    send_item(CMD_READ, REG_STATUS, '0);
  endtask

  task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int count);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) send_random_item();
  endtask

  task automatic test_output_hold_off();
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    hold_off_cycles = 120;
    repeat (60) send_random_item();
  endtask

  task automatic test_drain_between_bursts();
    send_idle_pct  = 10;
    recv_stall_pct = 10;
    repeat (25) send_random_item();
    in_tvalid <= 1'b0;
    wait_for_drain();
    repeat (25) send_random_item();
  endtask

  // result side: check of each transfer
  always @(posedge clk) begin
    result_t got;
    result_t exp;
    if (rst_n && out_tvalid && out_tready) begin
      got = result_t'(out_tdata[$bits(result_t)-1:0]);
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        mismatch_count++;
      end else begin
        exp = pending_results.pop_front();
        if (got !== exp) begin
          $display("%0t: mismatch exp rd=%h irq=%b ev=%b got rd=%h irq=%b ev=%b", $time,
                   exp.read_data, exp.irq, exp.update_event,
                   got.read_data, got.irq, got.update_event);
          mismatch_count++;
        end
      end
    end
  end

  // result side: random stalls and long hold-offs
  always @(posedge clk) begin
    if (hold_off_cycles > 0) begin
      hold_off_cycles--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[general_purpose_reload_timer_unit] ERROR");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_values();
    test_one_shot_overflow();
    test_update_disable();
    test_generate_down();
    test_random_traffic(0, 0, 350);
    test_random_traffic(74, 0, 350);
    test_random_traffic(0, 74, 350);
    test_random_traffic(10, 10, 300);
    test_output_hold_off();
    test_drain_between_bursts();
    in_tvalid <= 1'b0;
    wait_for_drain();
    repeat (PIPE_DEPTH + 8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[general_purpose_reload_timer_unit] OK");
    end else begin
      $display("[general_purpose_reload_timer_unit] ERROR");
    end
    $finish;
  end

endmodule
